// ===== src/gtsp_pkg.sv =====
`default_nettype none
// ============================================================================
// gtsp_pkg: shared types and constants of the slot pool
// Sizes, operation and status codes, channel payloads and the command and
// status groups that join the controller to the datapath.
// ============================================================================
package gtsp_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int ACT_W = IDX_W + 1;
    localparam int TAG_W = 32;
    localparam int SEQ_W = 64;
    localparam int LEN_W = 16;

    typedef enum logic [2:0] {
        KIND_RESERVE  = 3'd0,
        KIND_COMMIT   = 3'd1,
        KIND_TAKE     = 3'd2,
        KIND_REL_RES  = 3'd3,
        KIND_REL_HELD = 3'd4,
        KIND_QUERY    = 3'd5,
        KIND_RESUME   = 3'd6,
        KIND_STOP     = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_RESERVED = 2'd1,
        SLOT_READY    = 2'd2,
        SLOT_HELD     = 2'd3
    } slot_status_t;

    typedef enum logic {
        CFG_BOOT_PAUSED  = 1'b0,
        CFG_ACTIVE_SLOTS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ADDR = 2'd1,
        ST_SCAN = 2'd2,
        ST_EXEC = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  slot_sel;
        logic [TAG_W-1:0]  slot_generation;
        logic [SEQ_W-1:0]  order_key;
        logic [LEN_W-1:0]  byte_count;
        logic              encode_complete;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  result_index;
        logic [TAG_W-1:0]  result_generation;
        logic [SEQ_W-1:0]  result_sequence;
        logic [LEN_W-1:0]  result_bytes;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic scan;
        logic exec;
    } gtsp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_take;
        logic scan_done;
        logic out_full;
    } gtsp_stat_t;

endpackage
`default_nettype wire

// ===== src/generation_tagged_slot_pool.sv =====
`default_nettype none
// ============================================================================
// generation_tagged_slot_pool: pool of generation-tagged record slots
// Sixteen slots that are reserved, committed, taken oldest first, released
// and queried through a request channel, with one result per request.
// ============================================================================
// Usage:
// A request is one transfer on in_valid/in_ready carrying an in_data
// struct; each request produces exactly one result transfer on
// out_valid/out_ready carrying an out_data struct, in request order.
// Configuration writes go over cfg_valid/cfg_ready with cfg_index and
// cfg_data; the port is always ready and must only be used while no
// request is outstanding.
// A take walks the record memory one slot per cycle through its single
// read port to find the oldest ready slot.
// Only one request is handled at a time; a new request is accepted once
// the previous one has made its update, even while the previous result
// still waits in the output register.
// When the receiver stalls, a finished result stays in the output
// register and the next request waits before updating any slot.
// Reset frees all slots, zeroes all tags, clears the pause and stop flags
// and selects all sixteen slots; no clearing pass is needed.
// ============================================================================
module generation_tagged_slot_pool (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire gtsp_pkg::req_t                in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output gtsp_pkg::rsp_t                     out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire gtsp_pkg::cfg_reg_t            cfg_index,
    input  wire logic [gtsp_pkg::ACT_W-1:0]    cfg_data
);
    import gtsp_pkg::*;

    gtsp_cmd_t  cmd;
    gtsp_stat_t stat;

    // Register writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    // The sequencer decides when each step of a request happens.
    gtsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns all slot state and the result register.
    gtsp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== src/gtsp_ctrl.sv =====
`default_nettype none
// ============================================================================
// gtsp_ctrl: operation sequencer of the slot pool
// Steps one request through capture, slot selection, the oldest-ready scan
// when the request is a take, and the single state update.
// ============================================================================
module gtsp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gtsp_pkg::gtsp_stat_t stat,
    output gtsp_pkg::gtsp_cmd_t      cmd
);
    import gtsp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.is_take ? ST_SCAN : ST_EXEC;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The update happens once, when the output register can take the result.
                if (!stat.out_full)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/gtsp_dpath.sv =====
`default_nettype none
// ============================================================================
// gtsp_dpath: slot state, record memory and result register
// Holds per-slot status and tags, the sequence and length memory, the pool
// flags and configuration, the free-slot encoder and the minimum scan.
// ============================================================================
module gtsp_dpath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gtsp_pkg::gtsp_cmd_t  cmd,
    output gtsp_pkg::gtsp_stat_t      stat,
    input  wire gtsp_pkg::req_t       in_data,
    input  wire logic                 cfg_we,
    input  wire gtsp_pkg::cfg_reg_t   cfg_index,
    input  wire logic [gtsp_pkg::ACT_W-1:0] cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output gtsp_pkg::rsp_t            out_data
);
    import gtsp_pkg::*;

    localparam int REC_W = SEQ_W + LEN_W;

    // Per-slot state, cleared by reset.
    slot_status_t      status_reg  [SLOTS];
    slot_status_t      status_next [SLOTS];
    logic [TAG_W-1:0]  tag_reg     [SLOTS];
    logic [TAG_W-1:0]  tag_next    [SLOTS];

    logic              paused_reg;
    logic              paused_next;
    logic              stopped_reg;
    logic              stopped_next;
    logic [ACT_W-1:0]  active_reg;
    logic [ACT_W-1:0]  active_next;

    // Sequence and length of each slot; only used after a commit wrote it.
    logic [REC_W-1:0]  rec_mem [SLOTS];
    logic [REC_W-1:0]  rec_rd_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [SEQ_W-1:0]  rd_seq;
    logic [LEN_W-1:0]  rd_len;

    req_t              req_reg;
    logic [IDX_W-1:0]  sel_idx_reg;
    logic              sel_ok_reg;

    logic [ACT_W-1:0]  scan_cnt_reg;
    logic              cand_vld_reg;
    logic [IDX_W-1:0]  cand_idx_reg;
    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SEQ_W-1:0]  best_seq_reg;
    logic              better;

    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              out_data_reg;
    rsp_t              rsp;

    logic [SLOTS-1:0]  free_vec;
    logic [SLOTS-1:0]  ready_vec;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;

    logic [IDX_W-1:0]  t_idx;
    slot_status_t      cur_status;
    logic [TAG_W-1:0]  cur_tag;
    logic [TAG_W-1:0]  inc_tag;
    logic              in_range;
    logic              tag_ok;

    assign rd_seq = rec_rd_reg[REC_W-1 -: SEQ_W];
    assign rd_len = rec_rd_reg[LEN_W-1:0];

    // Slot vectors over the slots in use.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            free_vec[i]  = (ACT_W'(i) < active_reg) && (status_reg[i] == SLOT_FREE);
            ready_vec[i] = (ACT_W'(i) < active_reg) && (status_reg[i] == SLOT_READY);
        end
    end

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Request capture and slot selection.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.prep)
        begin
            sel_idx_reg <= (req_reg.kind == KIND_RESERVE) ? free_idx : req_reg.slot_sel;
            sel_ok_reg  <= free_found;
        end
    end

    // Record memory: one write port, one registered read port.
    assign rd_addr = cmd.scan ? scan_cnt_reg[IDX_W-1:0] : req_reg.slot_sel;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[t_idx] <= {req_reg.order_key, req_reg.byte_count};
        end
        rec_rd_reg <= rec_mem[rd_addr];
    end

    // Oldest-ready scan: one slot read per cycle, each compared in the cycle after its read.
    assign better = cand_vld_reg && (!best_found_reg || (rd_seq < best_seq_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            cand_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.prep)
        begin
            scan_cnt_reg   <= '0;
            cand_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            scan_cnt_reg   <= scan_cnt_reg + ACT_W'(1);
            cand_vld_reg   <= (scan_cnt_reg < ACT_W'(SLOTS)) &&
                              ready_vec[scan_cnt_reg[IDX_W-1:0]];
            best_found_reg <= best_found_reg | better;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            cand_idx_reg <= scan_cnt_reg[IDX_W-1:0];
            if (better)
            begin
                best_idx_reg <= cand_idx_reg;
                best_seq_reg <= rd_seq;
            end
        end
    end

    // Operation on the selected slot.
    assign t_idx      = (req_reg.kind == KIND_TAKE) ? best_idx_reg : sel_idx_reg;
    assign cur_status = status_reg[t_idx];
    assign cur_tag    = tag_reg[t_idx];
    assign inc_tag    = (cur_tag == '1) ? TAG_W'(1) : cur_tag + TAG_W'(1);
    assign in_range   = {1'b0, req_reg.slot_sel} < active_reg;
    assign tag_ok     = cur_tag == req_reg.slot_generation;

    always_comb
    begin
        status_next  = status_reg;
        tag_next     = tag_reg;
        paused_next  = paused_reg;
        stopped_next = stopped_reg;
        active_next  = active_reg;
        mem_we       = 1'b0;
        rsp          = '0;
        rsp.result_index = req_reg.slot_sel;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOOT_PAUSED:  paused_next = cfg_data[0];
                CFG_ACTIVE_SLOTS: active_next = cfg_data;
                default:          active_next = active_reg;
            endcase
        end

        if (cmd.exec)
        begin
            unique case (req_reg.kind)
                KIND_RESERVE:
                begin
                    if (!stopped_reg && !paused_reg && sel_ok_reg)
                    begin
                        tag_next[t_idx]       = inc_tag;
                        status_next[t_idx]    = SLOT_RESERVED;
                        rsp.ok                = 1'b1;
                        rsp.result_index      = t_idx;
                        rsp.result_generation = inc_tag;
                    end
                end
                KIND_COMMIT:
                begin
                    if (in_range && (cur_status == SLOT_RESERVED) && tag_ok)
                    begin
                        if (req_reg.encode_complete)
                        begin
                            status_next[t_idx] = SLOT_READY;
                            mem_we             = 1'b1;
                            rsp.ok             = 1'b1;
                        end
                        else
                        begin
                            // An encoding that did not fit gives the slot back.
                            status_next[t_idx] = SLOT_FREE;
                        end
                    end
                end
                KIND_TAKE:
                begin
                    if (best_found_reg)
                    begin
                        status_next[t_idx]    = SLOT_HELD;
                        rsp.ok                = 1'b1;
                        rsp.result_index      = t_idx;
                        rsp.result_generation = cur_tag;
                    end
                end
                KIND_REL_RES:
                begin
                    if (in_range && (cur_status == SLOT_RESERVED) && tag_ok)
                    begin
                        status_next[t_idx] = SLOT_FREE;
                        rsp.ok             = 1'b1;
                    end
                end
                KIND_REL_HELD:
                begin
                    if (in_range && (cur_status == SLOT_HELD) && tag_ok)
                    begin
                        status_next[t_idx] = SLOT_FREE;
                        rsp.ok             = 1'b1;
                    end
                end
                KIND_QUERY:
                begin
                    if (in_range && (cur_status == SLOT_HELD) && tag_ok)
                    begin
                        rsp.ok              = 1'b1;
                        rsp.result_sequence = rd_seq;
                        rsp.result_bytes    = rd_len;
                    end
                end
                KIND_RESUME:
                begin
                    paused_next = 1'b0;
                    rsp.ok      = 1'b1;
                end
                KIND_STOP:
                begin
                    stopped_next = 1'b1;
                    rsp.ok       = 1'b1;
                end
                default:
                begin
                    rsp.ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= SLOT_FREE;
                tag_reg[i]    <= '0;
            end
            paused_reg  <= 1'b0;
            stopped_reg <= 1'b0;
            active_reg  <= ACT_W'(SLOTS);
        end
        else
        begin
            status_reg  <= status_next;
            tag_reg     <= tag_next;
            paused_reg  <= paused_next;
            stopped_reg <= stopped_next;
            active_reg  <= active_next;
        end
    end

    // Result register.
    assign out_valid_next = cmd.exec | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign stat.is_take   = req_reg.kind == KIND_TAKE;
    assign stat.scan_done = scan_cnt_reg == ACT_W'(SLOTS);
    assign stat.out_full  = out_valid_reg & ~out_ready;

endmodule
`default_nettype wire

// ===== src/gtsp_chk.sv =====
`default_nettype none
// ============================================================================
// gtsp_chk: port-level checks of the slot pool
// Watches the request and result channels of the top level.
// ============================================================================
module gtsp_chk (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_ready,
    input  wire gtsp_pkg::req_t in_data,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire gtsp_pkg::rsp_t out_data
);
    import gtsp_pkg::*;

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Flag requests accepted while the output is free always succeed.
    a_flag_ok: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid &&
        (in_data.kind == KIND_RESUME || in_data.kind == KIND_STOP)
        |-> ##3 out_valid && out_data.ok)
        else $error("resume or stop did not complete");

    // A failed operation reports no tag, sequence or length.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.result_generation == '0 &&
        out_data.result_sequence == '0 && out_data.result_bytes == '0)
        else $error("failed result carries data");

endmodule

bind generation_tagged_slot_pool gtsp_chk u_gtsp_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
